>>> src/bcrc_pkg.sv
// shared constants, types and the crc byte update for the block crc16 checker
package bcrc_pkg;

	localparam int unsigned HEADER_BYTES = 4;
	localparam logic [15:0] CRC_POLY = 16'ha001;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [15:0] BYTE_MASK = 16'h00ff;
	localparam logic [19:0] DATA_BYTES_RST = 20'd8188;
	localparam int unsigned DATA_BYTES_W = 20;

	// register indexes on the config port
	typedef enum logic {
		REG_DATA_BYTES = 1'b0,
		REG_NONE = 1'b1
	} reg_idx_t;

	// one result beat, crc in the low bits
	typedef struct packed {
		logic        crc_match;
		logic [15:0] computed_crc;
	} result_t;

	// reflected crc-16/arc, one byte, bitwise form of the table lookup
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = (crc ^ {8'h00, b}) & BYTE_MASK;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return (crc >> 8) ^ c;
	endfunction

endpackage

>>> src/bcrc_cfg.sv
// config register file and effective data byte count
module bcrc_cfg
	import bcrc_pkg::*;
#(
	parameter int POSITION_WIDTH = 20,
	localparam int CNT_W = (POSITION_WIDTH > 20) ? POSITION_WIDTH + 1 : 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [CNT_W-1:0] eff_count
);

	localparam logic [CNT_W-1:0] LIMIT =
		(CNT_W'(1) << POSITION_WIDTH) - CNT_W'(HEADER_BYTES);

	logic [DATA_BYTES_W-1:0] data_bytes_q;
	reg_idx_t                idx;
	logic [CNT_W-1:0]        n;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bytes_q <= DATA_BYTES_RST;
		end else if (psel && penable && pwrite && pready && idx == REG_DATA_BYTES) begin
			data_bytes_q <= pwdata[DATA_BYTES_W-1:0];
		end
	end

	always_comb begin
		unique case (idx)
			REG_DATA_BYTES: prdata = {{(32-DATA_BYTES_W){1'b0}}, data_bytes_q};
			default:        prdata = '0;
		endcase
	end

	// zero counts as one, and the count saturates so the position never wraps
	always_comb begin
		n = CNT_W'(data_bytes_q);
		if (n == '0) begin
			n = CNT_W'(1);
		end
		if (n > LIMIT) begin
			n = LIMIT;
		end
		eff_count = n;
	end

endmodule

>>> src/bcrc_datapath.sv
// input register, header/crc state and result register
module bcrc_datapath
	import bcrc_pkg::*;
#(
	parameter int POSITION_WIDTH = 20,
	localparam int CNT_W = (POSITION_WIDTH > 20) ? POSITION_WIDTH + 1 : 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] eff_count,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_result
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [15:0]               crc_q;
	logic [31:0]               stored_q;
	logic                      res_valid_q;
	result_t                   res_q;

	logic                      is_header;
	logic [15:0]               crc_new;
	logic [POSITION_WIDTH-1:0] taken;
	logic                      last;
	logic                      adv;
	logic [31:0]               stored_new;

	assign is_header = (pos_q[POSITION_WIDTH-1:2] == '0);
	assign crc_new   = crc_byte(crc_q, byte_s1);
	assign taken     = pos_q - POSITION_WIDTH'(HEADER_BYTES - 1);
	assign last      = !is_header && (CNT_W'(taken) >= eff_count);
	// a beat with a result waits only while the output register is held
	assign adv       = valid_s1 && (!last || !res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;

	always_comb begin
		stored_new = stored_q;
		unique case (pos_q[1:0])
			2'd0:    stored_new[7:0]   = byte_s1;
			2'd1:    stored_new[15:8]  = byte_s1;
			2'd2:    stored_new[23:16] = byte_s1;
			default: stored_new[31:24] = byte_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CRC_INIT;
			stored_q <= '0;
		end else if (adv) begin
			if (is_header) begin
				stored_q <= stored_new;
				pos_q    <= pos_q + POSITION_WIDTH'(1);
			end else if (last) begin
				pos_q    <= '0;
				crc_q    <= CRC_INIT;
				stored_q <= '0;
			end else begin
				crc_q <= crc_new;
				pos_q <= pos_q + POSITION_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last) begin
			res_q.computed_crc <= crc_new;
			res_q.crc_match    <= (stored_q == {16'h0000, crc_new});
		end
	end

	assign out_valid  = res_valid_q;
	assign out_result = res_q;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last |=> pos_q == '0 && crc_q == CRC_INIT && stored_q == '0)
		else $error("block end did not clear the block state");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> stored_q == '0 && crc_q == CRC_INIT)
		else $error("state not clean at start of block");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input register refused a beat");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !out_ready |=> res_valid_q && $stable(res_q))
		else $error("pending result lost or changed");

	a_header_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		is_header |-> !last)
		else $error("block ended inside the header");

endmodule

>>> src/block_crc16_checker.sv
// top level of the block crc16 checker
//
//  port group   dir   beat contents
//  s_*          in    one stream byte (check word bytes first, lsb first, then data)
//  m_*          out   crc-16/arc of the block data and the match flag, one per block
//  apb          in    data_bytes register at byte address 0
//
// one byte per cycle sustained while no held result stalls the input; a byte passes the input
// register and its result, if any, then lands in the output register;
// the crc byte update and the compare sit between these two registers
// reset clears the position, crc, check word and output valid; data_bytes
// resets to 8188. a held result stalls input only on a block's last byte
module block_crc16_checker
	import bcrc_pkg::*;
#(
	parameter int POSITION_WIDTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] computed_crc, [16] crc_match, [23:17] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = (POSITION_WIDTH > 20) ? POSITION_WIDTH + 1 : 21;

	logic [CNT_W-1:0] eff_count;
	result_t          result;

	bcrc_cfg #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.eff_count(eff_count)
	);

	bcrc_datapath #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_count (eff_count),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_result(result)
	);

	assign m_tdata = {7'b0000000, result};

endmodule

>>> tb/sv/crc16_block_monitor.sv
// watches the byte stream, result stream and config port, predicts and checks each result
`timescale 1ns / 100ps

module crc16_block_monitor
	import bcrc_pkg::*;
#(
	parameter int POSITION_WIDTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [15:0] computed_crc, [16] crc_match, [23:17] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	localparam logic [15:0] ARC_POLY = 16'ha001;
	localparam logic [19:0] RESET_COUNT = 20'd8188;
	localparam int unsigned CHECK_WORD_BYTES = 4;
	localparam longint unsigned MAX_DATA_LEN = (64'd1 << POSITION_WIDTH) - 64'd4;

	logic [19:0]               data_len_reg;
	logic [POSITION_WIDTH-1:0] block_pos;
	logic [15:0]               crc_so_far;
	logic [31:0]               check_word;
	result_t                   crc_results_due[$];
	int                        mismatches;

	// reflected crc-16/arc, one input bit at a time
	function automatic logic [15:0] arc_crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ ARC_POLY;
			end
		end
		return r;
	endfunction

	// zero means one byte, and the count is clipped so the position never wraps
	function automatic longint unsigned data_len_now();
		longint unsigned n;
		n = (data_len_reg == 20'd0) ? 64'd1 : 64'(data_len_reg);
		if (n > MAX_DATA_LEN) begin
			n = MAX_DATA_LEN;
		end
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t         got;
		result_t         due;
		longint unsigned taken;
		if (!arst_n) begin
			data_len_reg = RESET_COUNT;
			block_pos = '0;
			crc_so_far = 16'h0000;
			check_word = 32'h0;
			crc_results_due.delete();
			mismatches = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && reg_idx_t'(paddr >> 2) == REG_DATA_BYTES) begin
				data_len_reg = pwdata[19:0];
			end

			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[16:0]);
				if (crc_results_due.size() == 0) begin
					$display("%0t: result beat with none due: expected nothing, got crc %h match %b",
						$time, got.computed_crc, got.crc_match);
					mismatches++;
				end else begin
					due = crc_results_due.pop_front();
					if (got.computed_crc !== due.computed_crc) begin
						$display("%0t: computed_crc: expected %h, got %h",
							$time, due.computed_crc, got.computed_crc);
						mismatches++;
					end
					if (got.crc_match !== due.crc_match) begin
						$display("%0t: crc_match: expected %b, got %b",
							$time, due.crc_match, got.crc_match);
						mismatches++;
					end
					if (m_tdata[23:17] !== 7'h00) begin
						$display("%0t: result pad bits: expected %h, got %h",
							$time, 7'h00, m_tdata[23:17]);
						mismatches++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (block_pos < CHECK_WORD_BYTES) begin
					check_word = check_word | (32'(s_tdata) << (8 * block_pos));
					block_pos = block_pos + 1'b1;
				end else begin
					crc_so_far = arc_crc_byte(crc_so_far, s_tdata);
					taken = 64'(block_pos) - 64'd3;
					if (taken >= data_len_now()) begin
						due.computed_crc = crc_so_far;
						due.crc_match = (check_word == {16'h0000, crc_so_far});
						crc_results_due.push_back(due);
						block_pos = '0;
						crc_so_far = 16'h0000;
						check_word = 32'h0;
					end else begin
						block_pos = block_pos + 1'b1;
					end
				end
			end

			errors <= mismatches;
			pending <= crc_results_due.size();
		end
	end

endmodule

>>> tb/sv/tb_block_crc16_checker.sv
// testbench top for the block crc16 checker: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_block_crc16_checker;
	import bcrc_pkg::*;

	localparam int POS_W = 20;
	localparam int SETTLE_CYCLES = 4;
	localparam int unsigned RANDOM_BYTES = 1300;

	typedef enum int {
		HDR_MATCH,
		HDR_HIGH_SET,
		HDR_BIT_FLIP,
		HDR_ONES,
		HDR_RANDOM
	} hdr_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;

	bit          no_gaps = 1'b0;
	int unsigned bytes_sent = 0;

	always #5 clk = ~clk;

	block_crc16_checker #(.POSITION_WIDTH(POS_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	crc16_block_monitor #(.POSITION_WIDTH(POS_W)) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(errors), .pending(pending)
	);

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_raw(input int unsigned n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// check word first, then n data bytes; fill < 0 gives random data
	task automatic send_block(input int unsigned n, input hdr_kind_t kind, input int fill);
		logic [7:0]  body[];
		logic [15:0] crc;
		logic [31:0] word;
		body = new[n];
		crc = CRC_INIT;
		foreach (body[i]) begin
			body[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
			crc = crc_byte(crc, body[i]);
		end
		case (kind)
			HDR_MATCH: begin
				word = {16'h0000, crc};
			end
			HDR_HIGH_SET: begin
				word = {16'($urandom_range(1, 65535)), crc};
			end
			HDR_BIT_FLIP: begin
				word = {16'h0000, crc} ^ (32'h1 << $urandom_range(0, 31));
			end
			HDR_ONES: begin
				word = 32'hffff_ffff;
			end
			default: begin
				word = $urandom;
			end
		endcase
		for (int k = 0; k < 4; k++) begin
			send_byte(word[8*k +: 8]);
		end
		foreach (body[i]) begin
			send_byte(body[i]);
		end
	endtask

	// stop sending until every due result is in, then let the pipeline drain
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random stalls, sometimes holding a waiting beat back
	initial begin
		int unsigned stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				m_tready <= 1'b0;
				do @(posedge clk); while (!m_tvalid);
				repeat (stall - 1) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int unsigned count;
		int unsigned blen;
		int unsigned pick;
		hdr_kind_t   kind;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'h0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a long run under the count left by reset gives no result, then a short
		// count ends the block on the next byte
		no_gaps = 1'b1;
		send_raw(4 + 100);
		settle();
		no_gaps = 1'b0;
		write_reg(REG_DATA_BYTES, 32'd1);
		send_raw(1);
		settle();

		// single data byte, extreme byte values and check words
		write_reg(REG_DATA_BYTES, 32'd1);
		send_block(1, HDR_MATCH, 8'h00);
		send_block(1, HDR_ONES, 8'hff);
		send_block(1, HDR_HIGH_SET, -1);
		settle();

		// zero count acts as one
		write_reg(REG_DATA_BYTES, 32'd0);
		send_block(1, HDR_MATCH, -1);
		send_block(1, HDR_BIT_FLIP, -1);
		settle();

		// a write beyond the register list changes nothing
		write_reg(REG_DATA_BYTES, 32'd3);
		write_reg(REG_NONE, 32'd9);
		send_block(3, HDR_MATCH, -1);
		settle();

		// count lowered below the bytes already taken ends on the next byte
		write_reg(REG_DATA_BYTES, 32'd20);
		send_raw(4 + 10);
		settle();
		write_reg(REG_DATA_BYTES, 32'd5);
		send_raw(1);
		settle();

		// count raised mid block
		write_reg(REG_DATA_BYTES, 32'd3);
		send_raw(4 + 2);
		settle();
		write_reg(REG_DATA_BYTES, 32'd6);
		send_raw(4);
		settle();

		// count changed inside the check word, which is never cut short
		write_reg(REG_DATA_BYTES, 32'd2);
		send_raw(2);
		settle();
		write_reg(REG_DATA_BYTES, 32'd1);
		send_raw(2 + 1);
		settle();

		// all ones keeps the block open, then a short count closes it
		write_reg(REG_DATA_BYTES, 32'hffff_ffff);
		no_gaps = 1'b1;
		send_raw(4 + 20);
		settle();
		write_reg(REG_DATA_BYTES, 32'd1);
		send_raw(1);
		settle();

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			// sometimes leave a block open across the count change
			if ($urandom_range(0, 7) == 0) begin
				send_raw($urandom_range(1, 14));
			end
			settle();
			pick = $urandom_range(0, 9);
			case (pick)
				0: count = 0;
				1: count = 1;
				8: count = $urandom_range(13, 64);
				9: begin
					count = $urandom_range(1, 8);
					write_reg(REG_NONE, $urandom);
				end
				default: count = $urandom_range(2, 12);
			endcase
			write_reg(REG_DATA_BYTES, {12'($urandom), 20'(count)});
			blen = (count == 0) ? 1 : count;
			repeat ($urandom_range(1, 6)) begin
				kind = hdr_kind_t'($urandom_range(0, 4));
				if ($urandom_range(0, 1) == 0) begin
					kind = HDR_MATCH;
				end
				send_block(blen, kind, -1);
			end
		end

		settle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
